FILE: design/whg_pkg.sv
// package for the waypoint heading guidance block
// types, constants and the cordic angle table shared by all modules but whg_ram
package whg_pkg;

    localparam int MaxWaypoints = 4096;
    localparam int IdxW         = $clog2(MaxWaypoints);
    localparam int CntW         = IdxW + 1;
    localparam int Lookahead    = 2;
    localparam int CordicSteps  = 16;
    localparam int StepW        = $clog2(CordicSteps + 1);
    localparam int PosW         = 40;
    localparam int DiffW        = 25;
    localparam int CordW        = 44;
    localparam int ZW           = 24;
    localparam int DistW        = 48;
    localparam int Deg360       = 23040;
    localparam int Deg180       = 11520;
    localparam int SatLim       = 8388608;

    localparam logic [1:0] CfgRadius   = 2'd0;
    localparam logic [1:0] CfgThrottle = 2'd1;
    localparam logic [1:0] CfgEnable   = 2'd2;

    typedef struct packed {
        logic                   operation;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [15:0]     heading;
    } t_in_item;

    typedef struct packed {
        logic signed [14:0] steering_angle;
        logic [7:0]         throttle_out;
        logic [11:0]        target_index;
    } t_out_item;

    typedef struct packed {
        logic load_wr;
        logic rd_issue;
        logic srch_eval;
        logic srch_init;
        logic cord_init;
        logic cord_step;
        logic out_load;
        logic arr_eval;
        logic [IdxW-1:0] rd_addr;
        logic [StepW-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic arrive;
    } t_sts;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [StepW-1:0] i);
        case (i)
            0: atan_entry = 24'sd737280;  1: atan_entry = 24'sd435242;
            2: atan_entry = 24'sd229970;  3: atan_entry = 24'sd116736;
            4: atan_entry = 24'sd58595;   5: atan_entry = 24'sd29326;
            6: atan_entry = 24'sd14667;   7: atan_entry = 24'sd7334;
            8: atan_entry = 24'sd3667;    9: atan_entry = 24'sd1833;
            10: atan_entry = 24'sd917;    11: atan_entry = 24'sd458;
            12: atan_entry = 24'sd229;    13: atan_entry = 24'sd115;
            14: atan_entry = 24'sd57;     15: atan_entry = 24'sd29;
            default: atan_entry = '0;
        endcase
    endfunction

endpackage

FILE: design/waypoint_heading_guidance.sv
// top level of the waypoint heading guidance block
// depends on whg_pkg, whg_ctrl, whg_datapath
//
// usage
//   input channel i_in_valid / o_in_ready carries t_in_item; operation 0 appends a
//   waypoint to the table while it has room, operation 1 is a position update
//   output channel o_out_valid / i_out_ready carries t_out_item
//   configuration: i_cfg_we, i_cfg_index, i_cfg_data, one write per cycle, no wait
// timing
//   the first update searches the whole table and gives no transfer; later updates
//   run the 16-step cordic, the registered ram reads and the arrival check and
//   give a result; with output off an update does only the ram reads and
//   the arrival check and gives no transfer; the block works on
//   one item at a time; a new item is taken as soon as the block is idle
// reset
//   synchronous active low; clears count, target, route flag and registers
//   to their defaults; table contents are undefined until loaded
// stall
//   the result holds in the output register until the receiver takes it; the
//   next item still runs and waits at its end until the register is free
module waypoint_heading_guidance import whg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [31:0] r_radius;
    logic [7:0]  r_throttle;
    logic        r_enable;
    t_cmd        w_cmd;
    t_sts        w_sts;
    logic [IdxW-1:0] w_target;
    logic signed [14:0] w_steer;
    t_in_item    r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 32'd4194304; r_throttle <= 8'd5; r_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgRadius:   r_radius <= i_cfg_data;
                CfgThrottle: r_throttle <= i_cfg_data[7:0];
                CfgEnable:   r_enable <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // hold the item for the whole computation
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_item <= i_in_data;
    end

    whg_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_item(i_in_data), .i_out_en(r_enable),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_target(w_target), .o_cmd(w_cmd), .i_sts(w_sts));

    t_in_item w_dp_item;
    assign w_dp_item = (i_in_valid && o_in_ready) ? i_in_data : r_item;

    whg_datapath u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_item(w_dp_item), .i_radius_sq(r_radius),
        .o_sts(w_sts), .o_steer(w_steer));

    assign o_out_data.steering_angle = w_steer;
    assign o_out_data.throttle_out   = r_throttle;
    assign o_out_data.target_index   = 12'(w_target);
endmodule

FILE: design/whg_ram.sv
// generic single port ram with registered read
// no dependencies
module whg_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: design/whg_datapath.sv
// datapath: waypoint tables, distance unit, cordic atan2, heading wrap
// depends on whg_pkg and whg_ram
module whg_datapath import whg_pkg::*; (
    input  logic        i_clk,
    input  t_cmd        i_cmd,
    input  t_in_item    i_item,
    input  logic [31:0] i_radius_sq,
    output t_sts        o_sts,
    output logic signed [14:0] o_steer
);
    logic [PosW-1:0] w_rx, w_ry;
    logic [IdxW-1:0] w_addr;
    logic signed [DiffW-1:0] w_dx, w_dy;
    logic signed [DistW-1:0] r_sqx, r_sqy;
    logic [DistW-1:0] w_dist;
    logic signed [CordW-1:0] r_x, r_y, n_x, n_y, w_xs, w_ys;
    logic signed [ZW-1:0] r_z, n_z;
    logic signed [DistW-1:0] r_best;
    logic signed [ZW-1:0] w_zr;
    logic signed [16:0] w_bear, w_hd, w_diff;
    logic r_zero, r_arr;

    assign w_addr = i_cmd.rd_addr;

    whg_ram #(.Width(PosW), .Depth(MaxWaypoints)) u_ram_x (
        .i_clk(i_clk), .i_we(i_cmd.load_wr), .i_addr(w_addr),
        .i_wdata(i_item.pos_x), .o_rdata(w_rx));
    whg_ram #(.Width(PosW), .Depth(MaxWaypoints)) u_ram_y (
        .i_clk(i_clk), .i_we(i_cmd.load_wr), .i_addr(w_addr),
        .i_wdata(i_item.pos_y), .o_rdata(w_ry));

    function automatic logic signed [DiffW-1:0] sat(input logic signed [PosW-1:0] a,
                                                     input logic signed [PosW-1:0] b);
        logic signed [PosW:0] d;
        d = {a[PosW-1], a} - {b[PosW-1], b};
        if (d > (PosW+1)'(SatLim)) sat = DiffW'(SatLim);
        else if (d < -(PosW+1)'(SatLim)) sat = -DiffW'(SatLim);
        else sat = DiffW'(d);
    endfunction

    assign w_dx   = sat(w_rx, i_item.pos_x);
    assign w_dy   = sat(w_ry, i_item.pos_y);
    assign w_dist = DistW'(r_sqx) + DistW'(r_sqy);
    assign w_xs   = r_x >>> i_cmd.step;
    assign w_ys   = r_y >>> i_cmd.step;

    always_comb begin
        n_x = r_x; n_y = r_y; n_z = r_z;
        if (i_cmd.cord_init) begin
            // fold left half plane onto the right
            if (w_dx < 0) begin
                n_x = -(CordW'(w_dx) <<< 16);
                n_y = -(CordW'(w_dy) <<< 16);
                n_z = ZW'(Deg180 * 256);
            end else begin
                n_x = CordW'(w_dx) <<< 16;
                n_y = CordW'(w_dy) <<< 16;
                n_z = '0;
            end
        end else if (i_cmd.cord_step) begin
            if (r_y >= 0) begin
                n_x = r_x + w_ys; n_y = r_y - w_xs; n_z = r_z + atan_entry(i_cmd.step);
            end else begin
                n_x = r_x - w_ys; n_y = r_y + w_xs; n_z = r_z - atan_entry(i_cmd.step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
        if (i_cmd.cord_init) r_zero <= (w_dx == 0) && (w_dy == 0);
        r_sqx <= w_dx * w_dx;
        r_sqy <= w_dy * w_dy;
        if (i_cmd.srch_init) r_best <= '1;
        else if (i_cmd.srch_eval && w_dist < r_best) r_best <= w_dist;
        r_arr <= (i_cmd.srch_eval && (w_dist < r_best || i_cmd.srch_init))
               || (i_cmd.arr_eval && w_dist < {16'd0, i_radius_sq});
    end
    // in search mode arrive means new best; in arrival mode inside radius
    assign o_sts.arrive = r_arr;

    always_comb begin
        w_zr = (r_z + ZW'(128)) >>> 8;
        if (r_zero) w_bear = '0;
        else if (w_zr < 0) w_bear = 17'(w_zr) + 17'(Deg360);
        else if (w_zr >= ZW'(Deg360)) w_bear = 17'(w_zr) - 17'(Deg360);
        else w_bear = 17'(w_zr);
        w_hd = 17'(i_item.heading);
        if (w_hd < 0) w_hd = w_hd + 17'(Deg360);
        if (w_hd < 0) w_hd = w_hd + 17'(Deg360);
        if (w_hd >= 17'(Deg360)) w_hd = w_hd - 17'(Deg360);
        w_diff = w_hd - w_bear;
        if (w_diff > 17'(Deg180)) w_diff = w_diff - 17'(Deg360);
        else if (w_diff < -17'(Deg180)) w_diff = w_diff + 17'(Deg360);
    end

    // output register, loaded once the previous result has gone
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) o_steer <= 15'(w_diff);
    end
endmodule

FILE: design/whg_ctrl.sv
// controller state machine: sequencing of load, search, steer and arrival
// depends on whg_pkg
module whg_ctrl import whg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_item,
    input  logic     i_out_en,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output logic [IdxW-1:0] o_target,
    output t_cmd     o_cmd,
    input  t_sts     i_sts
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_SRCH = 9'b000000010, S_SRDL = 9'b000000100,
        S_LRD  = 9'b000001000, S_LDL  = 9'b000010000, S_CORD = 9'b000100000,
        S_ARD  = 9'b001000000, S_ADL  = 9'b010000000, S_OUT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CntW-1:0] r_count, n_count, r_si, n_si;
    logic [IdxW-1:0] r_tgt, n_tgt, r_cand, n_cand, r_out_tgt, n_out_tgt;
    logic [1:0] r_ph, n_ph;
    logic [StepW-1:0] r_step, n_step;
    logic r_ready, n_ready, r_first, n_first, r_emit, n_emit;
    logic [CntW-1:0] w_look;
    logic [IdxW-1:0] w_clamp;

    assign w_look  = CntW'(r_tgt) + CntW'(Lookahead);
    assign w_clamp = (w_look >= r_count) ? IdxW'(r_count - 1'b1) : w_look[IdxW-1:0];
    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_emit;
    assign o_target = r_out_tgt;

    always_comb begin
        n_state = r_state; n_count = r_count; n_si = r_si; n_tgt = r_tgt;
        n_cand = r_cand; n_ph = r_ph; n_step = r_step; n_ready = r_ready;
        n_first = r_first; n_emit = r_emit; n_out_tgt = r_out_tgt;
        o_cmd = '0;
        o_cmd.rd_addr = w_clamp;
        o_cmd.step = r_step;
        if (r_emit && i_out_ready) n_emit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (!i_item.operation) begin
                        o_cmd.rd_addr = r_count[IdxW-1:0];
                        if (r_count < CntW'(MaxWaypoints)) begin
                            o_cmd.load_wr = 1'b1;
                            n_count = r_count + 1'b1;
                        end
                    end else if (!r_ready) begin
                        n_ready = 1'b1;
                        n_si = '0; n_ph = '0; n_first = 1'b1;
                        if (r_count != 0) n_state = S_SRCH;
                    end else begin
                        n_cand = r_tgt;
                        n_state = i_out_en ? S_LRD : S_ARD;
                        n_first = i_out_en;
                    end
                end
            end
            // pipelined search: read, diff, square, compare
            S_SRCH: begin
                o_cmd.rd_addr = r_si[IdxW-1:0];
                o_cmd.srch_init = (r_si == 0);
                n_si = r_si + 1'b1;
                if (r_si == r_count - 1'b1) n_state = S_SRDL;
                if (r_si >= 2) begin
                    o_cmd.srch_eval = 1'b1;
                end
                if (r_si >= 3 && i_sts.arrive) n_tgt = IdxW'(r_si - 3);
                n_ph = '0;
            end
            S_SRDL: begin
                // drain last entries
                n_si = r_si + 1'b1;
                if (r_ph < 2'd2) o_cmd.srch_eval = (r_si >= 2);
                if (r_si >= 3 && i_sts.arrive) n_tgt = IdxW'(r_si - 3);
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd3) n_state = S_IDLE;
            end
            S_LRD: begin
                n_state = S_LDL; n_ph = '0;
            end
            S_LDL: begin
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd1) begin
                    o_cmd.cord_init = 1'b1;
                    n_step = '0;
                    n_state = S_CORD;
                end
            end
            S_CORD: begin
                if (r_step == StepW'(CordicSteps)) begin
                    n_state = S_ARD;
                end else begin
                    o_cmd.cord_step = 1'b1;
                    n_step = r_step + 1'b1;
                end
            end
            S_ARD: begin
                o_cmd.rd_addr = (r_tgt >= r_count) ? IdxW'(r_count - 1'b1) : r_tgt;
                n_ph = '0;
                n_state = S_ADL;
            end
            S_ADL: begin
                o_cmd.rd_addr = (r_tgt >= r_count) ? IdxW'(r_count - 1'b1) : r_tgt;
                n_ph = r_ph + 1'b1;
                if (r_ph == 2'd1) o_cmd.arr_eval = 1'b1;
                if (r_ph == 2'd2) begin
                    if (i_sts.arrive && r_tgt != IdxW'(MaxWaypoints - 1)) n_tgt = r_tgt + 1'b1;
                    n_state = r_first ? S_OUT : S_IDLE;
                end
            end
            S_OUT: begin
                // wait until the output register is free
                if (!r_emit || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_emit = 1'b1;
                    n_out_tgt = r_cand;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_tgt <= '0; r_ready <= 1'b0;
            r_emit <= 1'b0; r_si <= '0; r_ph <= '0; r_step <= '0; r_first <= 1'b0;
            r_cand <= '0; r_out_tgt <= '0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_tgt <= n_tgt; r_ready <= n_ready;
            r_emit <= n_emit; r_si <= n_si; r_ph <= n_ph; r_step <= n_step;
            r_first <= n_first; r_cand <= n_cand; r_out_tgt <= n_out_tgt;
        end
    end
endmodule
